@@ rtl/ows_pkg.sv @@
`default_nettype none

package ows_pkg;

	// widths of the search bookkeeping
	localparam int PosW = 7;
	localparam int RomW = 64;
	localparam int FamW = 4;

	// bit position one past the last rom bit, and the end of the family byte
	localparam logic [PosW-1:0] RomBitsEnd  = 7'd65;
	localparam logic [PosW-1:0] FamilyLimit = 7'd9;

	// item command codes
	localparam logic CmdStart = 1'b0;
	localparam logic CmdPair  = 1'b1;

	// result status codes
	typedef enum logic [2:0] {
		StSend   = 3'd0,
		StWrite  = 3'd1,
		StFound  = 3'd2,
		StZero   = 3'd3,
		StNoMore = 3'd4,
		StNoPres = 3'd5,
		StNoResp = 3'd6,
		StIgnore = 3'd7
	} status_t;

	// one input beat
	typedef struct packed {
		logic cmd;
		logic restart;
		logic presence;
		logic id_bit;
		logic id_cmp;
	} item_t;

	// one result beat
	typedef struct packed {
		status_t         status;
		logic            direction;
		logic [RomW-1:0] rom_id;
		logic [FamW-1:0] family_discrepancy;
		logic            last_device;
	} result_t;

	// search memory carried from item to item
	typedef struct packed {
		logic [RomW-1:0] rom;
		logic [PosW-1:0] last_disc;
		logic [PosW-1:0] zero_pos;
		logic [PosW-1:0] bit_pos;
		logic [FamW-1:0] family_disc;
		logic            last_dev;
		logic            pass_active;
	} srch_state_t;

endpackage

`default_nettype wire

@@ rtl/ows_in_if.sv @@
`default_nettype none

interface ows_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic restart;
	logic presence;
	logic id_bit;
	logic id_cmp;

	modport source (
		output valid, cmd, restart, presence, id_bit, id_cmp,
		input  ready
	);
	modport sink (
		input  valid, cmd, restart, presence, id_bit, id_cmp,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/ows_out_if.sv @@
`default_nettype none

interface ows_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        direction;
	logic [63:0] rom_id;
	logic [3:0]  family_discrepancy;
	logic        last_device;

	modport source (
		output valid, status, direction, rom_id, family_discrepancy, last_device,
		input  ready
	);
	modport sink (
		input  valid, status, direction, rom_id, family_discrepancy, last_device,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/ows_decide.sv @@
`default_nettype none

module ows_decide (
	input  ows_pkg::item_t       item,
	input  ows_pkg::srch_state_t st,
	output ows_pkg::srch_state_t nxt,
	output ows_pkg::result_t     res
);

	logic [ows_pkg::PosW-1:0] pos;
	logic [ows_pkg::PosW-1:0] pos_m1;
	logic [ows_pkg::PosW-1:0] pos_nxt;
	logic [5:0]               idx;
	logic [ows_pkg::RomW-1:0] bit_mask;
	logic [ows_pkg::RomW-1:0] rom_new;
	logic [ows_pkg::PosW-1:0] zero_new;
	logic                     tie;
	logic                     dir;

	// bit slot addressed by the current position
	assign pos      = st.bit_pos;
	assign pos_m1   = pos - 7'd1;
	assign idx      = pos_m1[5:0];
	assign bit_mask = {{(ows_pkg::RomW-1){1'b0}}, 1'b1} << idx;
	assign pos_nxt  = pos + 7'd1;

	// direction choice: follow a clean bit, else replay or branch at a discrepancy
	assign tie = (item.id_bit == item.id_cmp);
	always_comb begin
		if (!tie) begin
			dir = item.id_bit;
		end else if (pos < st.last_disc) begin
			dir = st.rom[idx];
		end else begin
			dir = (pos == st.last_disc);
		end
	end

	assign rom_new  = dir ? (st.rom | bit_mask) : (st.rom & ~bit_mask);
	assign zero_new = (tie && !dir) ? pos : st.zero_pos;

	// next search memory and status
	always_comb begin
		nxt           = st;
		res.status    = ows_pkg::StIgnore;
		res.direction = 1'b0;
		if (item.cmd == ows_pkg::CmdStart) begin
			if (item.restart) begin
				nxt.last_disc   = '0;
				nxt.last_dev    = 1'b0;
				nxt.family_disc = '0;
			end
			if (nxt.last_dev) begin
				nxt.last_disc   = '0;
				nxt.family_disc = '0;
				nxt.last_dev    = 1'b0;
				nxt.pass_active = 1'b0;
				res.status      = ows_pkg::StNoMore;
			end else if (!item.presence) begin
				nxt.last_disc   = '0;
				nxt.family_disc = '0;
				nxt.last_dev    = 1'b0;
				nxt.pass_active = 1'b0;
				res.status      = ows_pkg::StNoPres;
			end else begin
				nxt.pass_active = 1'b1;
				nxt.bit_pos     = 7'd1;
				nxt.zero_pos    = '0;
				res.status      = ows_pkg::StSend;
			end
		end else if (!st.pass_active) begin
			res.status = ows_pkg::StIgnore;
		end else if (item.id_bit && item.id_cmp) begin
			nxt.last_disc   = '0;
			nxt.family_disc = '0;
			nxt.last_dev    = 1'b0;
			nxt.pass_active = 1'b0;
			res.status      = ows_pkg::StNoResp;
		end else begin
			res.direction = dir;
			nxt.rom       = rom_new;
			nxt.zero_pos  = zero_new;
			nxt.bit_pos   = pos_nxt;
			if (tie && !dir && (pos < ows_pkg::FamilyLimit)) begin
				nxt.family_disc = pos[ows_pkg::FamW-1:0];
			end
			if (pos_nxt < ows_pkg::RomBitsEnd) begin
				res.status = ows_pkg::StWrite;
			end else begin
				nxt.pass_active = 1'b0;
				nxt.last_disc   = zero_new;
				nxt.last_dev    = (zero_new == '0) ? 1'b1 : st.last_dev;
				if (rom_new == '0) begin
					nxt.last_disc   = '0;
					nxt.family_disc = '0;
					nxt.last_dev    = 1'b0;
					res.status      = ows_pkg::StZero;
				end else begin
					res.status = ows_pkg::StFound;
				end
			end
		end
		res.rom_id             = nxt.rom;
		res.family_discrepancy = nxt.family_disc;
		res.last_device        = nxt.last_dev;
	end

endmodule

`default_nettype wire

@@ rtl/onewire_rom_search_engine_unit.sv @@
// throughput: one item per cycle while results are taken; input register, decision logic, result register
// while a result waits to be taken, stage one can still take one more item
// reset (arst_n low) empties both registers and clears the search memory,
// with the bit position set to one
`default_nettype none

module onewire_rom_search_engine_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ows_in_if.sink     item,
	ows_out_if.source  result
);

	ows_pkg::item_t       item_s1;
	logic                 valid_s1;
	ows_pkg::srch_state_t st_q;
	ows_pkg::srch_state_t st_nxt;
	ows_pkg::result_t     res_nxt;
	ows_pkg::result_t     res_q;
	logic                 res_valid_q;
	logic                 adv;

	// stage one moves on when the result register is free or being emptied
	assign adv        = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= '{cmd: item.cmd, restart: item.restart, presence: item.presence,
				id_bit: item.id_bit, id_cmp: item.id_cmp};
		end
	end

	// decision logic
	ows_decide u_decide (
		.item (item_s1),
		.st   (st_q),
		.nxt  (st_nxt),
		.res  (res_nxt)
	);

	// search memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{bit_pos: 7'd1, default: '0};
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid              = res_valid_q;
	assign result.status             = res_q.status;
	assign result.direction          = res_q.direction;
	assign result.rom_id             = res_q.rom_id;
	assign result.family_discrepancy = res_q.family_discrepancy;
	assign result.last_device        = res_q.last_device;

	// bit position stays within the rom plus one
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.bit_pos >= 7'd1) && (st_q.bit_pos <= ows_pkg::RomBitsEnd))
		else $error("bit position out of range");

	// a last-device flag is only ever set with no pass running
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.last_dev |-> !st_q.pass_active)
		else $error("pass active with last device flagged");

	// family discrepancy never points past the family byte
	a_fam_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.family_disc < 4'd9)
		else $error("family discrepancy out of range");

	// a found device never carries an all-zero id
	a_found_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.status == ows_pkg::StFound)) |-> (res_q.rom_id != '0))
		else $error("found status with zero rom id");

	// a held result keeps the item in stage one from moving on
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_valid_q && !result.ready) |=> (valid_s1 && $stable(st_q)))
		else $error("stage one moved while result stalled");

endmodule

`default_nettype wire

@@ tb/tb_onewire_rom_search_engine_unit.sv @@
`timescale 1ns / 100ps

module tb_onewire_rom_search_engine_unit;

	localparam int StallLimit  = 1000;
	localparam int TargetItems = 650;

	// one row of the directed table: an item, and a typed-in result where it is obvious
	typedef struct {
		ows_pkg::item_t   it;
		bit               typed;
		ows_pkg::result_t res;
	} dir_row_t;

	logic clk;
	logic arst_n;

	ows_in_if  item_if ();
	ows_out_if result_if ();

	onewire_rom_search_engine_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	ows_pkg::srch_state_t search_state;
	ows_pkg::result_t     pending_results [$];
	int                   mismatch_cnt;
	int                   decisions_sent;
	bit                   no_idle;
	int                   idle_cycles;
	dir_row_t             directed_tbl [17];

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// drops the remembered discrepancies and ends the running pass
	function automatic void wipe_search_memory();
		search_state.last_disc   = '0;
		search_state.family_disc = '0;
		search_state.last_dev    = 1'b0;
		search_state.pass_active = 1'b0;
	endfunction

	// search decision for one beat, advancing the predicted state
	function automatic ows_pkg::result_t predict_search_step(ows_pkg::item_t it);
		ows_pkg::result_t         r;
		logic [ows_pkg::PosW-1:0] pos;
		logic [ows_pkg::RomW-1:0] mask;
		logic                     dir;
		r   = '0;
		dir = 1'b0;
		if (it.cmd == ows_pkg::CmdStart) begin
			if (it.restart) begin
				search_state.last_disc   = '0;
				search_state.last_dev    = 1'b0;
				search_state.family_disc = '0;
			end
			if (search_state.last_dev) begin
				wipe_search_memory();
				r.status = ows_pkg::StNoMore;
			end else if (!it.presence) begin
				wipe_search_memory();
				r.status = ows_pkg::StNoPres;
			end else begin
				search_state.pass_active = 1'b1;
				search_state.bit_pos     = 7'd1;
				search_state.zero_pos    = '0;
				r.status = ows_pkg::StSend;
			end
		end else if (!search_state.pass_active) begin
			r.status = ows_pkg::StIgnore;
		end else if (it.id_bit && it.id_cmp) begin
			wipe_search_memory();
			r.status = ows_pkg::StNoResp;
		end else begin
			pos  = search_state.bit_pos;
			mask = ows_pkg::RomW'(1) << 6'(pos - 7'd1);
			// bus agrees: follow it; otherwise take the path the memory points at
			if (it.id_bit != it.id_cmp) begin
				dir = it.id_bit;
			end else begin
				if (pos < search_state.last_disc)
					dir = |(search_state.rom & mask);
				else
					dir = (pos == search_state.last_disc);
				if (!dir) begin
					search_state.zero_pos = pos;
					if (pos < ows_pkg::FamilyLimit)
						search_state.family_disc = pos[ows_pkg::FamW-1:0];
				end
			end
			search_state.rom = dir ? (search_state.rom | mask) : (search_state.rom & ~mask);
			pos = pos + 7'd1;
			search_state.bit_pos = pos;
			if (pos < ows_pkg::RomBitsEnd) begin
				r.status = ows_pkg::StWrite;
			end else begin
				// last rom bit written: close the pass
				search_state.pass_active = 1'b0;
				search_state.last_disc   = search_state.zero_pos;
				if (search_state.last_disc == '0)
					search_state.last_dev = 1'b1;
				if (search_state.rom == '0) begin
					wipe_search_memory();
					r.status = ows_pkg::StZero;
				end else begin
					r.status = ows_pkg::StFound;
				end
			end
		end
		r.direction          = dir;
		r.rom_id             = search_state.rom;
		r.family_discrepancy = search_state.family_disc;
		r.last_device        = search_state.last_dev;
		return r;
	endfunction

	function automatic dir_row_t mk_row(logic cmd, logic restart, logic presence, logic idb,
			logic cmpb, bit typed, ows_pkg::status_t st, logic dir);
		dir_row_t row;
		row.it              = {cmd, restart, presence, idb, cmpb};
		row.typed           = typed;
		row.res             = '0;
		row.res.status      = st;
		row.res.direction   = dir;
		return row;
	endfunction

	// predict, queue the expectation, then hand the beat to the block
	task automatic send_item(input ows_pkg::item_t it, input bit typed,
			input ows_pkg::result_t typed_res, output ows_pkg::result_t pred);
		pred = predict_search_step(it);
		pending_results.push_back(typed ? typed_res : pred);
		if (pred.status != ows_pkg::StIgnore)
			decisions_sent++;
		no_idle = (decisions_sent >= 250 && decisions_sent < 400);
		while (!no_idle && $urandom_range(0, 99) < 10) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid    <= 1'b1;
		item_if.cmd      <= it.cmd;
		item_if.restart  <= it.restart;
		item_if.presence <= it.presence;
		item_if.id_bit   <= it.id_bit;
		item_if.id_cmp   <= it.id_cmp;
		do @(posedge clk); while (!item_if.ready);
	endtask

	// unstructured beats
	task automatic send_noise(int n);
		ows_pkg::result_t r;
		for (int i = 0; i < n; i++)
			send_item(ows_pkg::item_t'(5'($urandom_range(0, 31))), 1'b0, '0, r);
	endtask

	// full enumeration of a small set of devices on a modeled wired-and bus
	task automatic run_search_session();
		logic [ows_pkg::RomW-1:0] devs [4];
		logic [ows_pkg::RomW-1:0] base;
		int                       ndev;
		int                       kind;
		int                       passes;
		int                       abort_at;
		int                       bi;
		bit [3:0]                 on_bus;
		bit                       done;
		bit                       aborted;
		bit                       restart_next;
		ows_pkg::item_t           it;
		ows_pkg::result_t         r;
		ndev = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
		kind = $urandom_range(0, 9);
		base = {$urandom, $urandom};
		if (kind == 1)
			base = '1;
		for (int d = 0; d < 4; d++) begin
			devs[d] = base;
			if (d != 0) begin
				devs[d][$urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63)] ^= 1'b1;
				if ($urandom_range(0, 1))
					devs[d][$urandom_range(0, 63)] ^= 1'b1;
			end
			if (kind == 0)
				devs[d] = '0;
		end
		done         = 1'b0;
		aborted      = 1'b0;
		restart_next = 1'b1;
		passes       = 0;
		while (!done && passes < 10) begin
			passes++;
			it            = ows_pkg::item_t'(5'($urandom_range(0, 31)));
			it.cmd        = ows_pkg::CmdStart;
			it.restart    = restart_next;
			it.presence   = (ndev != 0);
			restart_next  = 1'b0;
			send_item(it, 1'b0, '0, r);
			if (r.status != ows_pkg::StSend) begin
				done = 1'b1;
			end else begin
				on_bus = '0;
				for (int d = 0; d < ndev; d++)
					on_bus[d] = 1'b1;
				abort_at = (!aborted && $urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : 64;
				for (int k = 0; k < abort_at; k++) begin
					bi            = int'(search_state.bit_pos) - 1;
					it            = ows_pkg::item_t'(5'($urandom_range(0, 31)));
					it.cmd        = ows_pkg::CmdPair;
					it.id_bit     = 1'b1;
					it.id_cmp     = 1'b1;
					for (int d = 0; d < 4; d++)
						if (on_bus[d]) begin
							if (devs[d][bi])
								it.id_cmp = 1'b0;
							else
								it.id_bit = 1'b0;
						end
					send_item(it, 1'b0, '0, r);
					// devices that lost the bit drop out of the pass
					for (int d = 0; d < 4; d++)
						if (on_bus[d] && devs[d][bi] != r.direction)
							on_bus[d] = 1'b0;
				end
				if (abort_at < 64) begin
					aborted      = 1'b1;
					restart_next = 1'b1;
					send_noise($urandom_range(0, 6));
				end else if (r.status == ows_pkg::StZero) begin
					done = 1'b1;
				end
			end
		end
	endtask

	task automatic report_mismatch(string field, logic [63:0] exp_val, logic [63:0] act_val);
		mismatch_cnt++;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
	endtask

	// result side: random back-pressure and checking of every beat taken
	initial begin
		ows_pkg::result_t got;
		ows_pkg::result_t exp_res;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_if.valid && result_if.ready) begin
				got.status             = ows_pkg::status_t'(result_if.status);
				got.direction          = result_if.direction;
				got.rom_id             = result_if.rom_id;
				got.family_discrepancy = result_if.family_discrepancy;
				got.last_device        = result_if.last_device;
				if (pending_results.size() == 0) begin
					mismatch_cnt++;
					$display("%0t: result beat with nothing expected, status %h", $time,
						got.status);
				end else begin
					exp_res = pending_results.pop_front();
					if (got.status !== exp_res.status)
						report_mismatch("status", exp_res.status, got.status);
					if (got.direction !== exp_res.direction)
						report_mismatch("direction", exp_res.direction, got.direction);
					if (got.rom_id !== exp_res.rom_id)
						report_mismatch("rom_id", exp_res.rom_id, got.rom_id);
					if (got.family_discrepancy !== exp_res.family_discrepancy)
						report_mismatch("family_discrepancy", exp_res.family_discrepancy,
							got.family_discrepancy);
					if (got.last_device !== exp_res.last_device)
						report_mismatch("last_device", exp_res.last_device, got.last_device);
				end
			end
			result_if.ready <= arst_n && (no_idle || $urandom_range(0, 99) >= 10);
		end
	end

	// watchdog on cycles without any beat
	initial begin
		idle_cycles = 0;
		while (idle_cycles < StallLimit) begin
			@(posedge clk);
			if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// reset, directed table, random sessions, drain
	initial begin
		ows_pkg::result_t r;
		search_state             = '0;
		search_state.bit_pos     = 7'd1;
		mismatch_cnt             = 0;
		decisions_sent           = 0;
		no_idle                  = 1'b0;
		arst_n           <= 1'b0;
		item_if.valid    <= 1'b0;
		item_if.cmd      <= ows_pkg::CmdStart;
		item_if.restart  <= 1'b0;
		item_if.presence <= 1'b0;
		item_if.id_bit   <= 1'b0;
		item_if.id_cmp   <= 1'b0;
		directed_tbl = '{
			mk_row(ows_pkg::CmdPair,  1'b0, 1'b0, 1'b1, 1'b0, 1'b1, ows_pkg::StIgnore, 1'b0),
			mk_row(ows_pkg::CmdStart, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, ows_pkg::StNoPres, 1'b0),
			mk_row(ows_pkg::CmdPair,  1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ows_pkg::StIgnore, 1'b0),
			mk_row(ows_pkg::CmdStart, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, ows_pkg::StSend,   1'b0),
			mk_row(ows_pkg::CmdPair,  1'b0, 1'b0, 1'b1, 1'b1, 1'b1, ows_pkg::StNoResp, 1'b0),
			mk_row(ows_pkg::CmdPair,  1'b0, 1'b0, 1'b0, 1'b1, 1'b1, ows_pkg::StIgnore, 1'b0),
			mk_row(ows_pkg::CmdStart, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, ows_pkg::StSend,   1'b0),
			mk_row(ows_pkg::CmdPair,  1'b0, 1'b0, 1'b0, 1'b1, 1'b1, ows_pkg::StWrite,  1'b0),
			mk_row(ows_pkg::CmdPair,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ows_pkg::StSend,   1'b0),
			mk_row(ows_pkg::CmdPair,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0, ows_pkg::StSend,   1'b0),
			mk_row(ows_pkg::CmdPair,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, ows_pkg::StSend,   1'b0),
			mk_row(ows_pkg::CmdStart, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, ows_pkg::StSend,   1'b0),
			mk_row(ows_pkg::CmdPair,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ows_pkg::StSend,   1'b0),
			mk_row(ows_pkg::CmdPair,  1'b0, 1'b0, 1'b1, 1'b1, 1'b0, ows_pkg::StSend,   1'b0),
			mk_row(ows_pkg::CmdStart, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, ows_pkg::StSend,   1'b0),
			mk_row(ows_pkg::CmdStart, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, ows_pkg::StSend,   1'b0),
			mk_row(ows_pkg::CmdPair,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0, ows_pkg::StSend,   1'b0)
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (directed_tbl[i])
			send_item(directed_tbl[i].it, directed_tbl[i].typed, directed_tbl[i].res, r);

		// random part: mostly complete searches, some loose beats
		while (decisions_sent < TargetItems) begin
			if ($urandom_range(0, 4) == 0)
				send_noise($urandom_range(5, 20));
			else
				run_search_session();
		end
		item_if.valid <= 1'b0;

		// drain and let the pipeline settle
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
